FILE: rtl/core/delta_timer_queue_macros.svh
// assertion macros used by the delta timer queue datapath
`ifndef DELTA_TIMER_QUEUE_MACROS_SVH
`define DELTA_TIMER_QUEUE_MACROS_SVH

// condition holds at every edge out of reset
`define DTQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("delta timer queue check failed");

// consequent holds in the same cycle as the antecedent
`define DTQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delta timer queue check failed");

// consequent holds in the cycle after the antecedent
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delta timer queue check failed");

`endif

FILE: rtl/core/dtq_pkg.sv
// shared constants, codes and command/status types for the delta timer queue
package dtq_pkg;

    localparam int CAPACITY   = 16;
    localparam int TAG_BITS   = 16;
    localparam int DELAY_BITS = 16;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int FRONT_W = DELAY_BITS + 1;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                load;
        logic                walk_step;
        logic                write_ins;
        logic                write_rem;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic walk_more;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/core/dtq_ctrl.sv
// sequencing state machine for the delta timer queue
module dtq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dtq_pkg::t_dp_stat  i_stat,
    output dtq_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [dtq_pkg::STATUS_W-1:0]   r_status;
    logic [dtq_pkg::STATUS_W-1:0]   n_status;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_remove) begin
                    if (i_stat.empty) begin
                        n_status = dtq_pkg::ST_EMPTY;
                        n_state  = S_FINISH;
                    end else begin
                        n_status = dtq_pkg::ST_DONE;
                        n_state  = S_REMOVE;
                    end
                end else begin
                    if (i_stat.full) begin
                        n_status = dtq_pkg::ST_FULL;
                        n_state  = S_FINISH;
                    end else begin
                        n_status = dtq_pkg::ST_DONE;
                        n_state  = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // one entry per cycle: subtract its delta while entries remain and the delay is larger
                if (i_stat.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.write_ins = 1'b1;
                n_state         = S_FINISH;
            end
            S_REMOVE: begin
                o_cmd.write_rem = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.status   = r_status;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= dtq_pkg::ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

FILE: rtl/core/dtq_datapath.sv
// entry store, delay walk and result register of the delta timer queue
`include "delta_timer_queue_macros.svh"

module dtq_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dtq_pkg::t_dp_cmd                     i_cmd,
    output dtq_pkg::t_dp_stat                    o_stat,
    input  logic                                 i_mode,
    input  logic [dtq_pkg::TAG_BITS-1:0]         i_tag,
    input  logic [dtq_pkg::DELAY_BITS-1:0]       i_delay,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [dtq_pkg::STATUS_W-1:0]         o_status,
    output logic [dtq_pkg::TAG_BITS-1:0]         o_removed_tag,
    output logic [dtq_pkg::CNT_W-1:0]            o_entry_count,
    output logic signed [dtq_pkg::FRONT_W-1:0]   o_front_delay
);

    logic [dtq_pkg::TAG_BITS-1:0]   r_tags   [dtq_pkg::CAPACITY];
    logic [dtq_pkg::DELAY_BITS-1:0] r_deltas [dtq_pkg::CAPACITY];
    logic [dtq_pkg::CNT_W-1:0]      r_count;

    logic                           r_mode;
    logic [dtq_pkg::TAG_BITS-1:0]   r_tag_in;
    logic [dtq_pkg::DELAY_BITS-1:0] r_rem;
    logic [dtq_pkg::CNT_W-1:0]      r_pos;
    logic [dtq_pkg::TAG_BITS-1:0]   r_removed;

    logic                              r_out_valid;
    logic [dtq_pkg::STATUS_W-1:0]      r_out_status;
    logic [dtq_pkg::TAG_BITS-1:0]      r_out_tag;
    logic [dtq_pkg::CNT_W-1:0]         r_out_count;
    logic [dtq_pkg::FRONT_W-1:0]       r_out_front;

    logic [dtq_pkg::DELAY_BITS-1:0] cur_delta;
    logic [dtq_pkg::CNT_W-1:0]      pos_next;
    logic [dtq_pkg::CNT_W-1:0]      count_inc;
    logic                           out_free;

    assign cur_delta = r_deltas[r_pos[dtq_pkg::IDX_W-1:0]];
    assign pos_next  = r_pos + dtq_pkg::CNT_W'(1);
    assign count_inc = r_count + dtq_pkg::CNT_W'(1);
    assign out_free  = !r_out_valid || i_ready;

    assign o_stat.is_remove = (r_mode == dtq_pkg::MODE_REMOVE);
    assign o_stat.full      = (r_count == dtq_pkg::CNT_W'(dtq_pkg::CAPACITY));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.walk_more = (r_pos < r_count) && (r_rem > cur_delta);
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_tag_in  <= i_tag;
            r_rem     <= i_delay;
            r_pos     <= '0;
            r_removed <= '0;
        end else if (i_cmd.walk_step) begin
            r_rem <= r_rem - cur_delta;
            r_pos <= pos_next;
        end else if (i_cmd.write_rem) begin
            r_removed <= r_tags[0];
        end
    end

    // insert shifts the slots behind its position back; remove moves every slot forward
    for (genvar g = 0; g < dtq_pkg::CAPACITY; g++) begin : g_slot
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == dtq_pkg::CAPACITY - 1) ? g : g + 1;
        always_ff @(posedge i_clk) begin
            if (i_cmd.write_ins) begin
                if (dtq_pkg::CNT_W'(g) > r_pos && dtq_pkg::CNT_W'(g) <= r_count) begin
                    r_tags[g] <= r_tags[PREV];
                    if (dtq_pkg::CNT_W'(g) == pos_next) begin
                        r_deltas[g] <= r_deltas[PREV] - r_rem;
                    end else begin
                        r_deltas[g] <= r_deltas[PREV];
                    end
                end else if (dtq_pkg::CNT_W'(g) == r_pos) begin
                    r_tags[g]   <= r_tag_in;
                    r_deltas[g] <= r_rem;
                end
            end else if (i_cmd.write_rem) begin
                r_tags[g]   <= r_tags[NEXT];
                r_deltas[g] <= r_deltas[NEXT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_ins) begin
            r_count <= count_inc;
        end else if (i_cmd.write_rem) begin
            r_count <= r_count - dtq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_tag    <= r_removed;
            r_out_count  <= r_count;
            // empty queue reads as all ones, i.e. minus one
            if (r_count == '0) begin
                r_out_front <= '1;
            end else begin
                r_out_front <= {1'b0, r_deltas[0]};
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_removed_tag = r_out_tag;
    assign o_entry_count = r_out_count;
    assign o_front_delay = r_out_front;

    `DTQ_ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_count <= dtq_pkg::CNT_W'(dtq_pkg::CAPACITY))
    `DTQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, i_cmd.write_ins, r_count == $past(count_inc))
    `DTQ_ASSERT_IMPLIES(a_walk_bound, i_clk, i_rst_n, i_cmd.walk_step, r_pos < r_count)
    `DTQ_ASSERT_IMPLIES(a_out_slot, i_clk, i_rst_n, i_cmd.out_load, out_free)

endmodule

FILE: rtl/core/delta_timer_queue.sv
// Delta timer queue: holds up to 16 tagged timers in expiry order, each storing its delay
// relative to the entry ahead, so the front delta is the time to the first expiry. One
// operation is taken at a time and gives one result. After the input transfer the control
// passes through its check state, then to remove, or to a walk and then insert, or straight
// to finish for a rejected insert or remove; the result is loaded in finish. The walk does
// one subtract and compare per stored entry per cycle and passes k entries (0 to 15). The
// next transfer in can be taken as the result appears in the output register. Finish
// waits only while an earlier result sits unaccepted in the output register.
module delta_timer_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_mode,
    input  logic [dtq_pkg::TAG_BITS-1:0]         i_tag,
    input  logic [dtq_pkg::DELAY_BITS-1:0]       i_delay,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [dtq_pkg::STATUS_W-1:0]         o_status,
    output logic [dtq_pkg::TAG_BITS-1:0]         o_removed_tag,
    output logic [dtq_pkg::CNT_W-1:0]            o_entry_count,
    output logic signed [dtq_pkg::FRONT_W-1:0]   o_front_delay
);

    dtq_pkg::t_dp_cmd  dp_cmd;
    dtq_pkg::t_dp_stat dp_stat;

    dtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    dtq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_mode        (i_mode),
        .i_tag         (i_tag),
        .i_delay       (i_delay),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_removed_tag (o_removed_tag),
        .o_entry_count (o_entry_count),
        .o_front_delay (o_front_delay)
    );

endmodule
